/* design/phat_cross_spectrum_bin_assert.svh */
// assertion macros for the phat cross spectrum block
`ifndef PHAT_CROSS_SPECTRUM_BIN_ASSERT_SVH
`define PHAT_CROSS_SPECTRUM_BIN_ASSERT_SVH
`ifndef SYNTHESIS
`define PHAT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("phat check failed");
`define PHAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("phat check failed");
`else
`define PHAT_ASSERT_NOW(label, ante, cons)
`define PHAT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* design/phat_pkg.sv */
// shared types, widths and helpers of the phat cross spectrum block
package phat_pkg;

  localparam int FFT_SIZE   = 4096;
  localparam int BIN_W      = 12;
  localparam int DATA_W     = 24;
  localparam int WEIGHT_W   = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int MAG_W      = PROD_W;
  localparam int NORM_W     = 30;
  localparam int UNIT_SHIFT = 20;
  localparam int SQ_PAD_W   = 64;
  localparam int ROOT_Q_W   = SQ_PAD_W / 2;
  localparam int ROOT_REM_W = ROOT_Q_W + 4;
  localparam int ROOT_W     = 31;
  localparam int QUO_W      = UNIT_SHIFT + 1;
  localparam int NUM_W      = NORM_W + UNIT_SHIFT + 1;
  localparam int DIV_PER    = 3;
  localparam int WPROD_W    = QUO_W + WEIGHT_W;
  localparam int WMAG_W     = WPROD_W + 1 - 12;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 12;

  localparam logic [BIN_W-1:0] LOW_CUT_RST  = 12'd96;
  localparam logic [BIN_W-1:0] HIGH_CUT_RST = 12'd1280;
  localparam logic [BIN_W-1:0] NUM_BINS_RST = BIN_W'((FFT_SIZE / 2 + 1) % 4096);
  localparam logic signed [DATA_W-1:0] UNIT_ONE = 24'sh100000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 8'd0,
    REG_LOW_CUT  = 8'd1,
    REG_HIGH_CUT = 8'd2,
    REG_NUM_BINS = 8'd3
  } cfg_reg_t;

  typedef enum logic {
    MODE_MASKED   = 1'b0,
    MODE_WEIGHTED = 1'b1
  } mode_t;

  typedef struct packed {
    logic [BIN_W-1:0]    bin;
    logic [WEIGHT_W-1:0] weight;
    mode_t               mode;
    logic                neg_re;
    logic                neg_im;
    logic                zero;
  } side_t;

  typedef struct packed {
    logic [MAG_W-1:0] re;
    logic [MAG_W-1:0] im;
  } mag_pair_t;

  function automatic logic bin_masked(logic [BIN_W-1:0] i, logic [BIN_W-1:0] lc,
                                      logic [BIN_W-1:0] hc, logic [BIN_W-1:0] n);
    logic signed [BIN_W+1:0] si, slc, shc, sn;
    si  = $signed({2'b00, i});
    slc = $signed({2'b00, lc});
    shc = $signed({2'b00, hc});
    sn  = $signed({2'b00, n});
    return (si < slc) || (si > sn - slc) || ((si > shc) && (si < sn - shc));
  endfunction

endpackage

/* design/phat_cross_spectrum_bin.sv */
// top level of the phat cross spectrum bin block
// One frequency bin enters per cycle when nothing stalls. Of the
// pipeline stages, 3 form the cross spectrum and its magnitudes, 2
// normalise, 18 take the squares and the square root (two root bits a stage),
// 8 run the two dividers (three quotient bits a stage) and 2 weight, round and
// saturate into the output register. Every stage has its own valid bit and
// moves whenever the stage after it is free, so a stalled output only holds
// up items behind it once the gaps in front have closed. Configuration takes
// effect for items accepted after the write; the write port is always ready.
`include "phat_cross_spectrum_bin_assert.svh"
module phat_cross_spectrum_bin import phat_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [BIN_W-1:0]         in_bin_index,
  input  logic signed [DATA_W-1:0] in_sig1_re,
  input  logic signed [DATA_W-1:0] in_sig1_im,
  input  logic signed [DATA_W-1:0] in_sig2_re,
  input  logic signed [DATA_W-1:0] in_sig2_im,
  input  logic [WEIGHT_W-1:0]      in_weight,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [BIN_W-1:0]         out_bin_out,
  output logic signed [DATA_W-1:0] out_re,
  output logic signed [DATA_W-1:0] out_im,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  mode_t            mode_r;
  logic [BIN_W-1:0] low_cut_r, high_cut_r, num_bins_r;

  side_t             in_side, x_side, n_side, s_side, d_side;
  logic              x_valid, x_ready, n_valid, n_ready;
  logic              s_valid, s_ready, d_valid, d_ready;
  logic [MAG_W-1:0]  x_re, x_im;
  logic [NORM_W-1:0] n_re, n_im, s_re, s_im;
  logic [ROOT_W-1:0] s_root;
  logic [QUO_W-1:0]  d_re, d_im;
  logic              out_masked;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_MASKED;
      low_cut_r  <= LOW_CUT_RST;
      high_cut_r <= HIGH_CUT_RST;
      num_bins_r <= NUM_BINS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:     mode_r     <= mode_t'(cfg_data[0]);
        REG_LOW_CUT:  low_cut_r  <= cfg_data;
        REG_HIGH_CUT: high_cut_r <= cfg_data;
        REG_NUM_BINS: num_bins_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_comb begin
    in_side.bin    = in_bin_index;
    in_side.weight = in_weight;
    in_side.mode   = mode_r;
    in_side.neg_re = 1'b0;
    in_side.neg_im = 1'b0;
    in_side.zero   = (mode_r == MODE_MASKED) &&
                     bin_masked(in_bin_index, low_cut_r, high_cut_r, num_bins_r);
  end

  phat_xspec u_xspec (
    .clk, .rst_n,
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_side    (in_side),
    .in_a       (in_sig1_re),
    .in_b       (in_sig1_im),
    .in_c       (in_sig2_re),
    .in_d       (in_sig2_im),
    .out_valid  (x_valid),
    .out_ready  (x_ready),
    .out_side   (x_side),
    .out_mag_re (x_re),
    .out_mag_im (x_im)
  );

  phat_norm u_norm (
    .clk, .rst_n,
    .in_valid  (x_valid),
    .in_ready  (x_ready),
    .in_side   (x_side),
    .in_mag_re (x_re),
    .in_mag_im (x_im),
    .out_valid (n_valid),
    .out_ready (n_ready),
    .out_side  (n_side),
    .out_re    (n_re),
    .out_im    (n_im)
  );

  phat_sqrt u_sqrt (
    .clk, .rst_n,
    .in_valid  (n_valid),
    .in_ready  (n_ready),
    .in_side   (n_side),
    .in_re     (n_re),
    .in_im     (n_im),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_side  (s_side),
    .out_re    (s_re),
    .out_im    (s_im),
    .out_root  (s_root)
  );

  phat_div u_div (
    .clk, .rst_n,
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_side   (s_side),
    .in_re     (s_re),
    .in_im     (s_im),
    .in_root   (s_root),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_side  (d_side),
    .out_u_re  (d_re),
    .out_u_im  (d_im)
  );

  phat_out u_out (
    .clk, .rst_n,
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_side   (d_side),
    .in_u_re   (d_re),
    .in_u_im   (d_im),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_bin   (out_bin_out),
    .out_re    (out_re),
    .out_im    (out_im)
  );

  assign out_masked = bin_masked(out_bin_out, low_cut_r, high_cut_r, num_bins_r);

  // an empty output stage means every stage can move, so input is open
  `PHAT_ASSERT_NOW(a_ready_on_gap, !out_valid, in_ready)
  `PHAT_ASSERT_NOW(a_masked_zero, out_valid && mode_r == MODE_MASKED && out_masked, out_re == '0 && out_im == '0)
  `PHAT_ASSERT_NOW(a_unit_bound, out_valid && mode_r == MODE_MASKED, out_re <= UNIT_ONE && out_re >= -UNIT_ONE && out_im <= UNIT_ONE && out_im >= -UNIT_ONE)
  `PHAT_ASSERT_NEXT(a_mode_write, cfg_valid && cfg_ready && cfg_index == REG_MODE, mode_r == mode_t'($past(cfg_data[0])))

endmodule

/* design/phat_xspec.sv */
// cross spectrum products, sums and magnitudes over three stages
module phat_xspec import phat_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  side_t                    in_side,
  input  logic signed [DATA_W-1:0] in_a,
  input  logic signed [DATA_W-1:0] in_b,
  input  logic signed [DATA_W-1:0] in_c,
  input  logic signed [DATA_W-1:0] in_d,
  output logic                     out_valid,
  input  logic                     out_ready,
  output side_t                    out_side,
  output logic [MAG_W-1:0]         out_mag_re,
  output logic [MAG_W-1:0]         out_mag_im
);

  localparam int NS = 3;

  logic [NS-1:0] v_r, v_nxt;
  logic [NS:0]   en;

  logic signed [PROD_W-1:0] p_ac_r, p_bd_r, p_bc_r, p_ad_r;
  logic signed [PROD_W-1:0] p_ac_nxt, p_bd_nxt, p_bc_nxt, p_ad_nxt;
  logic signed [SUM_W-1:0]  r_r, c_r;
  logic [MAG_W-1:0]         mr_r, mc_r;
  side_t                    sd0_r, sd1_r, sd2_r, sd2_nxt;

  always_comb begin
    en[NS] = out_ready;
    for (int s = NS - 1; s >= 0; s--) en[s] = !v_r[s] || en[s+1];
  end

  always_comb begin
    v_nxt = v_r;
    if (en[0]) v_nxt[0] = in_valid;
    for (int s = 1; s < NS; s++) if (en[s]) v_nxt[s] = v_r[s-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  assign p_ac_nxt = PROD_W'(in_a) * PROD_W'(in_c);
  assign p_bd_nxt = PROD_W'(in_b) * PROD_W'(in_d);
  assign p_bc_nxt = PROD_W'(in_b) * PROD_W'(in_c);
  assign p_ad_nxt = PROD_W'(in_a) * PROD_W'(in_d);

  always_comb begin
    sd2_nxt        = sd1_r;
    sd2_nxt.neg_re = r_r[SUM_W-1];
    sd2_nxt.neg_im = c_r[SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_ac_r <= p_ac_nxt;
      p_bd_r <= p_bd_nxt;
      p_bc_r <= p_bc_nxt;
      p_ad_r <= p_ad_nxt;
      sd0_r  <= in_side;
    end
    if (en[1]) begin
      r_r   <= SUM_W'(p_ac_r) + SUM_W'(p_bd_r);
      c_r   <= SUM_W'(p_bc_r) - SUM_W'(p_ad_r);
      sd1_r <= sd0_r;
    end
    if (en[2]) begin
      mr_r  <= r_r[SUM_W-1] ? MAG_W'(-r_r) : MAG_W'(r_r);
      mc_r  <= c_r[SUM_W-1] ? MAG_W'(-c_r) : MAG_W'(c_r);
      sd2_r <= sd2_nxt;
    end
  end

  assign in_ready   = en[0];
  assign out_valid  = v_r[NS-1];
  assign out_side   = sd2_r;
  assign out_mag_re = mr_r;
  assign out_mag_im = mc_r;

endmodule

/* design/phat_norm.sv */
// joint normalising shift of both magnitudes, two stages of three steps
module phat_norm import phat_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  side_t             in_side,
  input  logic [MAG_W-1:0]  in_mag_re,
  input  logic [MAG_W-1:0]  in_mag_im,
  output logic              out_valid,
  input  logic              out_ready,
  output side_t             out_side,
  output logic [NORM_W-1:0] out_re,
  output logic [NORM_W-1:0] out_im
);

  localparam int NS = 2;

  logic [NS-1:0] v_r, v_nxt;
  logic [NS:0]   en;

  mag_pair_t p0_r, p1_r, p0_nxt, p1_nxt;
  side_t     sd0_r, sd1_r, sd0_nxt;

  function automatic mag_pair_t norm_step(mag_pair_t p, int sh);
    mag_pair_t  r;
    logic [MAG_W-1:0] o;
    r = p;
    o = p.re | p.im;
    if ((o >> (MAG_W - sh)) == '0) begin
      r.re = p.re << sh;
      r.im = p.im << sh;
    end
    return r;
  endfunction

  always_comb begin
    en[NS] = out_ready;
    for (int s = NS - 1; s >= 0; s--) en[s] = !v_r[s] || en[s+1];
  end

  always_comb begin
    v_nxt = v_r;
    if (en[0]) v_nxt[0] = in_valid;
    for (int s = 1; s < NS; s++) if (en[s]) v_nxt[s] = v_r[s-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  always_comb begin
    p0_nxt = norm_step(norm_step(norm_step('{re: in_mag_re, im: in_mag_im}, 32), 16), 8);
    p1_nxt = norm_step(norm_step(norm_step(p0_r, 4), 2), 1);
    sd0_nxt      = in_side;
    sd0_nxt.zero = in_side.zero || ((in_mag_re | in_mag_im) == '0);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p0_r  <= p0_nxt;
      sd0_r <= sd0_nxt;
    end
    if (en[1]) begin
      p1_r  <= p1_nxt;
      sd1_r <= sd0_r;
    end
  end

  // top bit of the larger magnitude lands on the msb of the kept slice
  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];
  assign out_side  = sd1_r;
  assign out_re    = p1_r.re[MAG_W-1 -: NORM_W];
  assign out_im    = p1_r.im[MAG_W-1 -: NORM_W];

endmodule

/* design/phat_sqrt.sv */
// squares, sum and a pipelined integer square root, two result bits a stage
module phat_sqrt import phat_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  side_t             in_side,
  input  logic [NORM_W-1:0] in_re,
  input  logic [NORM_W-1:0] in_im,
  output logic              out_valid,
  input  logic              out_ready,
  output side_t             out_side,
  output logic [NORM_W-1:0] out_re,
  output logic [NORM_W-1:0] out_im,
  output logic [ROOT_W-1:0] out_root
);

  localparam int RS = SQ_PAD_W / 4;
  localparam int NS = RS + 2;
  localparam int SQ_W = 2 * NORM_W;

  typedef struct packed {
    logic [SQ_PAD_W-1:0]   x;
    logic [ROOT_REM_W-1:0] rem;
    logic [ROOT_Q_W-1:0]   q;
  } root_t;

  logic [NS-1:0] v_r, v_nxt;
  logic [NS:0]   en;

  logic [NORM_W-1:0]   re_r [NS];
  logic [NORM_W-1:0]   im_r [NS];
  side_t               sd_r [NS];
  logic [SQ_W-1:0]     sqa_r, sqb_r;
  logic [SQ_PAD_W-1:0] sum_r;
  root_t               rt_r   [RS];
  root_t               rt_nxt [RS];

  function automatic root_t root_step(root_t t);
    root_t r;
    logic [ROOT_REM_W-1:0] rn, trial;
    rn    = {t.rem[ROOT_REM_W-3:0], t.x[SQ_PAD_W-1 -: 2]};
    trial = {2'b00, t.q, 2'b01};
    r.x   = t.x << 2;
    if (rn >= trial) begin
      r.rem = rn - trial;
      r.q   = {t.q[ROOT_Q_W-2:0], 1'b1};
    end else begin
      r.rem = rn;
      r.q   = {t.q[ROOT_Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    en[NS] = out_ready;
    for (int s = NS - 1; s >= 0; s--) en[s] = !v_r[s] || en[s+1];
  end

  always_comb begin
    v_nxt = v_r;
    if (en[0]) v_nxt[0] = in_valid;
    for (int s = 1; s < NS; s++) if (en[s]) v_nxt[s] = v_r[s-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  always_comb begin
    rt_nxt[0] = root_step(root_step('{x: sum_r, rem: '0, q: '0}));
    for (int j = 1; j < RS; j++) rt_nxt[j] = root_step(root_step(rt_r[j-1]));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      re_r[0] <= in_re;
      im_r[0] <= in_im;
      sd_r[0] <= in_side;
      sqa_r   <= SQ_W'(in_re) * SQ_W'(in_re);
      sqb_r   <= SQ_W'(in_im) * SQ_W'(in_im);
    end
    for (int s = 1; s < NS; s++) begin
      if (en[s]) begin
        re_r[s] <= re_r[s-1];
        im_r[s] <= im_r[s-1];
        sd_r[s] <= sd_r[s-1];
      end
    end
    if (en[1]) sum_r <= SQ_PAD_W'(sqa_r) + SQ_PAD_W'(sqb_r);
    for (int j = 0; j < RS; j++) if (en[j+2]) rt_r[j] <= rt_nxt[j];
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];
  assign out_side  = sd_r[NS-1];
  assign out_re    = re_r[NS-1];
  assign out_im    = im_r[NS-1];
  assign out_root  = rt_r[RS-1].q[ROOT_W-1:0];

endmodule

/* design/phat_div.sv */
// rounded unit parts by two pipelined restoring dividers
module phat_div import phat_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  side_t             in_side,
  input  logic [NORM_W-1:0] in_re,
  input  logic [NORM_W-1:0] in_im,
  input  logic [ROOT_W-1:0] in_root,
  output logic              out_valid,
  input  logic              out_ready,
  output side_t             out_side,
  output logic [QUO_W-1:0]  out_u_re,
  output logic [QUO_W-1:0]  out_u_im
);

  localparam int DS = QUO_W / DIV_PER;
  localparam int NS = DS + 1;

  typedef struct packed {
    logic [QUO_W-1:0]  low;
    logic [ROOT_W-1:0] rem;
    logic [QUO_W-1:0]  q;
  } quo_t;

  logic [NS-1:0] v_r, v_nxt;
  logic [NS:0]   en;

  side_t             sd_r [NS];
  logic [ROOT_W-1:0] m_r  [NS];
  quo_t              qr_r [NS];
  quo_t              qi_r [NS];
  quo_t              qr_nxt [NS];
  quo_t              qi_nxt [NS];
  logic [NUM_W-1:0]  nr, ni;

  function automatic quo_t div_step(quo_t t, logic [ROOT_W-1:0] m);
    quo_t r;
    logic [ROOT_W:0] rn;
    rn    = {t.rem, t.low[QUO_W-1]};
    r.low = t.low << 1;
    if (rn >= {1'b0, m}) begin
      r.rem = ROOT_W'(rn - {1'b0, m});
      r.q   = {t.q[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = rn[ROOT_W-1:0];
      r.q   = {t.q[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic quo_t div_group(quo_t t, logic [ROOT_W-1:0] m);
    quo_t r;
    r = t;
    for (int k = 0; k < DIV_PER; k++) r = div_step(r, m);
    return r;
  endfunction

  always_comb begin
    en[NS] = out_ready;
    for (int s = NS - 1; s >= 0; s--) en[s] = !v_r[s] || en[s+1];
  end

  always_comb begin
    v_nxt = v_r;
    if (en[0]) v_nxt[0] = in_valid;
    for (int s = 1; s < NS; s++) if (en[s]) v_nxt[s] = v_r[s-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  // half the divisor added in for round to nearest
  assign nr = {1'b0, in_re, UNIT_SHIFT'(0)} + NUM_W'(in_root >> 1);
  assign ni = {1'b0, in_im, UNIT_SHIFT'(0)} + NUM_W'(in_root >> 1);

  always_comb begin
    qr_nxt[0] = '{low: nr[QUO_W-1:0], rem: ROOT_W'(nr[NUM_W-1:QUO_W]), q: '0};
    qi_nxt[0] = '{low: ni[QUO_W-1:0], rem: ROOT_W'(ni[NUM_W-1:QUO_W]), q: '0};
    for (int s = 1; s < NS; s++) begin
      qr_nxt[s] = div_group(qr_r[s-1], m_r[s-1]);
      qi_nxt[s] = div_group(qi_r[s-1], m_r[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sd_r[0] <= in_side;
      m_r[0]  <= in_root;
    end
    for (int s = 1; s < NS; s++) begin
      if (en[s]) begin
        sd_r[s] <= sd_r[s-1];
        m_r[s]  <= m_r[s-1];
      end
    end
    for (int s = 0; s < NS; s++) begin
      if (en[s]) begin
        qr_r[s] <= qr_nxt[s];
        qi_r[s] <= qi_nxt[s];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];
  assign out_side  = sd_r[NS-1];
  assign out_u_re  = qr_r[NS-1].q;
  assign out_u_im  = qi_r[NS-1].q;

endmodule

/* design/phat_out.sv */
// weighting, rounding, sign and saturation, ending in the output register
module phat_out import phat_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  side_t                    in_side,
  input  logic [QUO_W-1:0]         in_u_re,
  input  logic [QUO_W-1:0]         in_u_im,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [BIN_W-1:0]         out_bin,
  output logic signed [DATA_W-1:0] out_re,
  output logic signed [DATA_W-1:0] out_im
);

  localparam int NS = 2;
  localparam logic [WMAG_W-1:0] POS_MAX = WMAG_W'(8388607);
  localparam logic [WMAG_W-1:0] NEG_MAX = WMAG_W'(8388608);

  logic [NS-1:0] v_r, v_nxt;
  logic [NS:0]   en;

  side_t                    sd0_r;
  logic [WPROD_W-1:0]       wr_r, wi_r;
  logic [QUO_W-1:0]         ur_r, ui_r;
  logic [BIN_W-1:0]         bin_r;
  logic signed [DATA_W-1:0] re_r, im_r, re_nxt, im_nxt;
  logic [WMAG_W-1:0]        mr, mi;

  function automatic logic signed [DATA_W-1:0] finish(logic [WMAG_W-1:0] mag, logic neg,
                                                      logic zero);
    logic signed [DATA_W-1:0] v;
    if (zero)                v = '0;
    else if (neg && mag > NEG_MAX)  v = {1'b1, {(DATA_W-1){1'b0}}};
    else if (neg)            v = DATA_W'(WMAG_W'(0) - mag);
    else if (mag > POS_MAX)  v = {1'b0, {(DATA_W-1){1'b1}}};
    else                     v = DATA_W'(mag);
    return v;
  endfunction

  always_comb begin
    en[NS] = out_ready;
    for (int s = NS - 1; s >= 0; s--) en[s] = !v_r[s] || en[s+1];
  end

  always_comb begin
    v_nxt = v_r;
    if (en[0]) v_nxt[0] = in_valid;
    for (int s = 1; s < NS; s++) if (en[s]) v_nxt[s] = v_r[s-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  // q4.12 weight, rounded half up on the magnitude
  always_comb begin
    if (sd0_r.mode == MODE_WEIGHTED) begin
      mr = WMAG_W'(((WPROD_W + 1)'(wr_r) + (WPROD_W + 1)'(2048)) >> 12);
      mi = WMAG_W'(((WPROD_W + 1)'(wi_r) + (WPROD_W + 1)'(2048)) >> 12);
    end else begin
      mr = WMAG_W'(ur_r);
      mi = WMAG_W'(ui_r);
    end
    re_nxt = finish(mr, sd0_r.neg_re, sd0_r.zero);
    im_nxt = finish(mi, sd0_r.neg_im, sd0_r.zero);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sd0_r <= in_side;
      ur_r  <= in_u_re;
      ui_r  <= in_u_im;
      wr_r  <= WPROD_W'(in_u_re) * WPROD_W'(in_side.weight);
      wi_r  <= WPROD_W'(in_u_im) * WPROD_W'(in_side.weight);
    end
    if (en[1]) begin
      bin_r <= sd0_r.bin;
      re_r  <= re_nxt;
      im_r  <= im_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];
  assign out_bin   = bin_r;
  assign out_re    = re_r;
  assign out_im    = im_r;

endmodule
